/* hdl/upd_pkg.sv */
`timescale 1ns / 1ps

package upd_pkg;

    localparam int WIN_DEPTH = 21;
    localparam int NUM_PAT   = 3;

    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_0      = 8'd48;
    localparam logic [7:0] CH_9      = 8'd57;
    localparam logic [7:0] CH_A      = 8'd65;
    localparam logic [7:0] CH_Z      = 8'd90;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LZ     = 8'h7A;
    localparam logic [7:0] CASE_GAP  = 8'd32;
    localparam logic [5:0] DIGIT_TEN = 6'd10;

    typedef logic [4:0] t_count;

    // Escape shortcuts matched right after a percent sign, zero padded.
    localparam logic [7:0] PAT_TAB [NUM_PAT][WIN_DEPTH] = '{
        '{"5", "C", "%", "5", "C", "r", "%", "5", "C", "%", "5", "C", "n",
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"5", "C", "%", "2", "2", "%", "2", "C", "%", "5", "C",
          "%", "2", "2", "%", "5", "C", "%", "5", "C", "n"},
        '{"5", "C", "%", "5", "C", "%", "5", "C", "%", "5", "C",
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam t_count     PAT_LEN [NUM_PAT] = '{5'd13, 5'd21, 5'd11};
    localparam logic [7:0] PAT_VAL [NUM_PAT] = '{8'd10, 8'd10, 8'd92};

    typedef enum logic [1:0] {
        POP_ONE,
        POP_ELEVEN,
        POP_THIRTEEN,
        POP_ALL
    } t_pop;

    localparam t_pop PAT_POP [NUM_PAT] = '{POP_THIRTEEN, POP_ALL, POP_ELEVEN};

    typedef enum logic [1:0] {
        PH_TEXT,
        PH_OPEN,
        PH_DIGIT
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_FAIL_HI,
        ST_FAIL_LO,
        ST_VERB,
        ST_END_RAW,
        ST_END_DEC
    } t_state;

    typedef struct packed {
        logic push;
        logic step;
        logic verb;
        logic fail_hi;
        logic fail_lo;
        logic end_raw;
        logic end_dec;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic len_short;
        logic last;
        logic wait_more;
        logic fail;
        logic empty_after;
        logic count_one;
        logic empty;
    } t_dp_status;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        return (c inside {[CH_LA:CH_LZ]}) ? c - CASE_GAP : c;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c inside {[CH_0:CH_9], [CH_A:CH_Z]});
    endfunction

    function automatic logic [5:0] digit_val(input logic [7:0] c);
        logic [7:0] d;
        if (c inside {[CH_0:CH_9]}) begin
            d = c - CH_0;
            return d[5:0];
        end
        d = c - CH_A;
        return d[5:0] + DIGIT_TEN;
    endfunction

endpackage

/* hdl/url_percent_decoder_unit.sv */
`timescale 1ns / 1ps

// Percent decoder for one string at a time: raw bytes in with tlast on the final
// byte, decoded bytes out, then one end-marker beat (tlast high, tuser[0] low)
// whose tuser[1] says whether the string was decoded (0: shorter than three bytes,
// copied verbatim). Each plain byte is accepted, then taken by one step of the
// single-step drain sequencer, which takes one held byte or a whole matched escape
// shortcut per step and, while the output is free, posts at most one beat per cycle
// into a one-deep output register. A good escape takes three accepted bytes and
// three steps; a failed escape re-emits its two held bytes as extra beats; bytes
// held while a long escape shortcut may still match are walked through one per
// cycle, output permitting, once it resolves (up to 21). The input stays ready
// only when idle; any beat stalls the sequencer until the output register is free.
module url_percent_decoder_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [1:0] m_axis_tuser,   // [0] byte_valid, [1] was_decoded
    output logic       m_axis_tlast
);
    import upd_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       byte_valid;
    logic       was_decoded;

    upd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    upd_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_byte     (s_axis_tdata),
        .i_in_last     (s_axis_tlast),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_out_byte    (m_axis_tdata),
        .o_byte_valid  (byte_valid),
        .o_string_end  (m_axis_tlast),
        .o_was_decoded (was_decoded)
    );

    assign m_axis_tuser = {was_decoded, byte_valid};

endmodule

/* hdl/upd_dp.sv */
`timescale 1ns / 1ps

module upd_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [7:0]          i_in_byte,
    input  logic                i_in_last,
    input  upd_pkg::t_dp_cmd    i_cmd,
    output upd_pkg::t_dp_status o_status,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [7:0]          o_out_byte,
    output logic                o_byte_valid,
    output logic                o_string_end,
    output logic                o_was_decoded
);
    import upd_pkg::*;

    logic [7:0] r_win [WIN_DEPTH];
    t_count     r_count, n_count;
    t_phase     r_phase, n_phase;
    logic [7:0] r_first, n_first;
    logic [7:0] r_lo, n_lo;
    logic [1:0] r_len, n_len;
    logic       r_last, n_last;

    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_bv;
    logic       r_out_end;
    logic       r_out_dec;

    logic [NUM_PAT-1:0] bad, full, pend;
    logic [1:0]         hit;
    logic               any_hit;
    logic [7:0]         c;
    logic               is_pct;
    logic [7:0]         hi_up, lo_up;
    logic [5:0]         hv, lv;
    logic [7:0]         dec_val;
    logic               digits_ok;
    logic               wait_more;

    logic       do_pop;
    t_pop       pop_sel;
    logic       emit;
    logic [7:0] e_byte;
    logic       e_bv, e_end, e_dec;

    assign c         = r_win[0];
    assign is_pct    = (c == CH_PCT);
    assign hi_up     = upcase(r_first);
    assign lo_up     = upcase(c);
    assign hv        = digit_val(hi_up);
    assign lv        = digit_val(lo_up);
    assign digits_ok = is_digit(hi_up) && is_digit(lo_up);
    // high*16 mod 256 keeps only the low nibble of the high digit
    assign dec_val   = {hv[3:0], 4'b0000} + {2'b00, lv};

    always_comb begin
        bad  = '0;
        full = '0;
        pend = '0;
        for (int p = 0; p < NUM_PAT; p++) begin
            for (int i = 0; i < WIN_DEPTH; i++) begin
                if ((5'(i) < PAT_LEN[p]) && (5'(i) < r_count)
                        && (r_win[i] != PAT_TAB[p][i])) begin
                    bad[p] = 1'b1;
                end
            end
            full[p] = !bad[p] && (r_count >= PAT_LEN[p]);
            pend[p] = !bad[p] && (r_count < PAT_LEN[p]) && !r_last;
        end
        hit = '0;
        for (int p = NUM_PAT - 1; p >= 0; p--) begin
            if (full[p]) begin
                hit = 2'(p);
            end
        end
        any_hit = |full;
    end

    assign wait_more = (r_phase == PH_OPEN) && !is_pct && !any_hit && (|pend);

    always_comb begin
        o_status.out_free    = !r_out_valid || i_out_ready;
        o_status.len_short   = (r_len < 2'd2);
        o_status.last        = r_last;
        o_status.wait_more   = wait_more;
        o_status.fail        = (r_phase == PH_DIGIT) && !is_pct && !digits_ok;
        o_status.empty_after = ((r_phase == PH_OPEN) && !is_pct && any_hit)
                             ? (r_count == PAT_LEN[hit]) : (r_count == 5'd1);
        o_status.count_one   = (r_count == 5'd1);
        o_status.empty       = (r_count == 5'd0);
    end

    always_comb begin
        n_count = r_count;
        n_phase = r_phase;
        n_first = r_first;
        n_lo    = r_lo;
        n_len   = r_len;
        n_last  = r_last;
        do_pop  = 1'b0;
        pop_sel = POP_ONE;
        emit    = 1'b0;
        e_byte  = 8'h00;
        e_bv    = 1'b1;
        e_end   = 1'b0;
        e_dec   = 1'b0;

        if (i_cmd.push) begin
            if (r_count < 5'(WIN_DEPTH)) begin
                n_count = r_count + 5'd1;
            end
            if (r_len != 2'd3) begin
                n_len = r_len + 2'd1;
            end
            n_last = i_in_last;
        end

        if (i_cmd.step) begin
            if (is_pct) begin
                n_phase = PH_OPEN;
                do_pop  = 1'b1;
            end else begin
                case (r_phase)
                    PH_TEXT: begin
                        emit   = 1'b1;
                        e_byte = (c == CH_PLUS) ? CH_SPACE : c;
                        do_pop = 1'b1;
                    end
                    PH_OPEN: begin
                        if (any_hit) begin
                            emit    = 1'b1;
                            e_byte  = PAT_VAL[hit];
                            do_pop  = 1'b1;
                            pop_sel = PAT_POP[hit];
                            n_phase = PH_TEXT;
                        end else if (!wait_more) begin
                            n_first = c;
                            do_pop  = 1'b1;
                            n_phase = PH_DIGIT;
                        end
                    end
                    PH_DIGIT: begin
                        do_pop  = 1'b1;
                        n_phase = PH_TEXT;
                        emit    = 1'b1;
                        if (digits_ok) begin
                            e_byte = dec_val;
                        end else begin
                            e_byte  = CH_PCT;
                            n_first = hi_up;
                            n_lo    = lo_up;
                        end
                    end
                    default: begin
                        n_phase = PH_TEXT;
                    end
                endcase
            end
        end

        if (i_cmd.verb) begin
            emit   = 1'b1;
            e_byte = c;
            do_pop = 1'b1;
        end

        if (i_cmd.fail_hi) begin
            emit   = 1'b1;
            e_byte = r_first;
        end

        if (i_cmd.fail_lo) begin
            emit   = 1'b1;
            e_byte = r_lo;
        end

        if (do_pop) begin
            case (pop_sel)
                POP_ONE:      n_count = r_count - 5'd1;
                POP_ELEVEN:   n_count = r_count - 5'd11;
                POP_THIRTEEN: n_count = r_count - 5'd13;
                default:      n_count = '0;
            endcase
        end

        if (i_cmd.end_raw || i_cmd.end_dec) begin
            emit    = 1'b1;
            e_byte  = 8'h00;
            e_bv    = 1'b0;
            e_end   = 1'b1;
            e_dec   = i_cmd.end_dec;
            n_count = '0;
            n_phase = PH_TEXT;
            n_first = 8'h00;
            n_len   = '0;
            n_last  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_phase <= PH_TEXT;
            r_first <= 8'h00;
            r_len   <= '0;
            r_last  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_phase <= n_phase;
            r_first <= n_first;
            r_len   <= n_len;
            r_last  <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo <= n_lo;
    end

    // window: shift toward entry 0 by one, 11 or 13 on a pop, write at the fill point on a push
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < WIN_DEPTH; i++) begin
            if (i_cmd.push && (r_count == 5'(i))) begin
                r_win[i] <= i_in_byte;
            end else if (do_pop) begin
                case (pop_sel)
                    POP_ONE:      r_win[i] <= r_win[(i + 1) % WIN_DEPTH];
                    POP_ELEVEN:   r_win[i] <= r_win[(i + 11) % WIN_DEPTH];
                    POP_THIRTEEN: r_win[i] <= r_win[(i + 13) % WIN_DEPTH];
                    default:      r_win[i] <= r_win[i];
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= e_byte;
            r_out_bv   <= e_bv;
            r_out_end  <= e_end;
            r_out_dec  <= e_dec;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_byte_valid  = r_out_bv;
    assign o_string_end  = r_out_end;
    assign o_was_decoded = r_out_dec;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 5'(WIN_DEPTH))
        else $error("window count beyond depth");

    a_no_wait_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && wait_more) |-> !r_last)
        else $error("pattern wait on final byte");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.end_raw || i_cmd.end_dec) |=>
            (r_count == '0 && r_phase == PH_TEXT && r_len == '0 && !r_last))
        else $error("string state not cleared after end marker");

    a_marker_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_end) |-> !r_out_bv)
        else $error("end marker flagged as byte");
`endif

endmodule

/* hdl/upd_ctrl.sv */
`timescale 1ns / 1ps

module upd_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_last,
    output logic                o_in_ready,
    input  upd_pkg::t_dp_status i_status,
    output upd_pkg::t_dp_cmd    o_cmd
);
    import upd_pkg::*;

    t_state r_state, n_state;
    t_state done_state;

    assign done_state = i_status.last ? ST_END_DEC : ST_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (!i_status.len_short) begin
                        n_state = ST_DRAIN;
                    end else if (i_in_last) begin
                        n_state = ST_VERB;
                    end
                end
            end
            ST_DRAIN: begin
                if (i_status.out_free) begin
                    if (i_status.wait_more) begin
                        n_state = done_state;
                    end else if (i_status.fail) begin
                        n_state = ST_FAIL_HI;
                    end else if (i_status.empty_after) begin
                        n_state = done_state;
                    end
                end
            end
            ST_FAIL_HI: begin
                if (i_status.out_free) begin
                    n_state = ST_FAIL_LO;
                end
            end
            ST_FAIL_LO: begin
                if (i_status.out_free) begin
                    n_state = i_status.empty ? done_state : ST_DRAIN;
                end
            end
            ST_VERB: begin
                if (i_status.out_free && i_status.count_one) begin
                    n_state = ST_END_RAW;
                end
            end
            ST_END_RAW, ST_END_DEC: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.push = i_in_valid;
            end
            ST_DRAIN:   o_cmd.step    = i_status.out_free;
            ST_FAIL_HI: o_cmd.fail_hi = i_status.out_free;
            ST_FAIL_LO: o_cmd.fail_lo = i_status.out_free;
            ST_VERB:    o_cmd.verb    = i_status.out_free;
            ST_END_RAW: o_cmd.end_raw = i_status.out_free;
            ST_END_DEC: o_cmd.end_dec = i_status.out_free;
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule
